// ===== hdl/bmss_pkg.sv =====
package bmss_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
    logic       overflow;
  } out_item_t;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // controller phases
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BC_CLR,
    ST_BC_FILL,
    ST_SUF_INIT,
    ST_SUF_CMP,
    ST_GS_INIT,
    ST_GS_PREF,
    ST_GS_PREF_J,
    ST_GS_MID,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SRCH_SHIFT,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_byte;
    logic new_pattern;
    logic bc_clr_init;
    logic bc_clr_step;
    logic bc_fill_init;
    logic bc_fill_step;
    logic suf_init;
    logic suf_next_i;
    logic suf_step_k;
    logic gs_init;
    logic gs_init_step;
    logic pref_init;
    logic pref_j_init;
    logic pref_j_step;
    logic pref_next_i;
    logic mid_init;
    logic mid_step;
    logic srch_init;
    logic srch_issue;
    logic srch_match;
    logic srch_shift;
    logic emit;
    logic close_text;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic bc_clr_done;
    logic bc_fill_done;
    logic pat_empty;
    logic suf_done;
    logic suf_cmp_eq;
    logic gs_init_done;
    logic pref_done;
    logic pref_hit;
    logic pref_j_done;
    logic mid_done;
    logic srch_done;
    logic srch_eq;
  } sts_t;

endpackage

// ===== hdl/bmss_ctrl.sv =====
module bmss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  bmss_pkg::in_item_t in_i,
  input  bmss_pkg::sts_t    sts_i,
  output logic              busy,
  output bmss_pkg::cmd_t    cmd_o
);
  import bmss_pkg::*;

  state_e state_q, state_d;
  logic   closed_q, closed_d;
  logic   srch_q, srch_d;   // tables built on the way to a search

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      closed_q <= 1'b0;
      srch_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      closed_q <= closed_d;
      srch_q   <= srch_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    closed_d = closed_q;
    srch_d   = srch_q;
    cmd_o    = '0;
    busy     = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.ld_byte = 1'b1;
          if (in_i.op == OP_PATTERN) begin
            cmd_o.new_pattern = closed_q;
            if (closed_q) closed_d = 1'b0;
            if (in_i.last) begin
              srch_d = 1'b0;
              cmd_o.bc_clr_init = 1'b1;
              state_d = ST_BC_CLR;
            end
          end else if (in_i.last) begin
            if (closed_q) begin
              cmd_o.srch_init = 1'b1;
              state_d = ST_SRCH_RD;
            end else begin
              srch_d = 1'b1;
              cmd_o.bc_clr_init = 1'b1;
              state_d = ST_BC_CLR;
            end
          end
        end
      end
      ST_BC_CLR: begin
        cmd_o.bc_clr_step = 1'b1;
        if (sts_i.bc_clr_done) begin
          cmd_o.bc_fill_init = 1'b1;
          state_d = ST_BC_FILL;
        end
      end
      ST_BC_FILL: begin
        // the step on the done cycle writes the last entry
        cmd_o.bc_fill_step = 1'b1;
        if (sts_i.bc_fill_done) begin
          if (sts_i.pat_empty) begin
            state_d = ST_GS_MID;
            cmd_o.mid_init = 1'b1;
          end else begin
            cmd_o.suf_init = 1'b1;
            state_d = ST_SUF_INIT;
          end
        end
      end
      ST_SUF_INIT: begin
        if (sts_i.suf_done) begin
          cmd_o.gs_init = 1'b1;
          state_d = ST_GS_INIT;
        end else begin
          state_d = ST_SUF_CMP;
        end
      end
      ST_SUF_CMP: begin
        if (sts_i.suf_cmp_eq) begin
          cmd_o.suf_step_k = 1'b1;
        end else begin
          cmd_o.suf_next_i = 1'b1;
        end
        state_d = ST_SUF_INIT;
      end
      ST_GS_INIT: begin
        cmd_o.gs_init_step = 1'b1;
        if (sts_i.gs_init_done) begin
          cmd_o.pref_init = 1'b1;
          state_d = ST_GS_PREF;
        end
      end
      ST_GS_PREF: begin
        if (sts_i.pref_done) begin
          cmd_o.mid_init = 1'b1;
          state_d = ST_GS_MID;
        end else if (sts_i.pref_hit) begin
          cmd_o.pref_j_init = 1'b1;
          state_d = ST_GS_PREF_J;
        end else begin
          cmd_o.pref_next_i = 1'b1;
        end
      end
      ST_GS_PREF_J: begin
        cmd_o.pref_j_step = 1'b1;
        if (sts_i.pref_j_done) begin
          cmd_o.pref_next_i = 1'b1;
          state_d = ST_GS_PREF;
        end
      end
      ST_GS_MID: begin
        if (sts_i.mid_done) begin
          closed_d = 1'b1;
          if (srch_q) begin
            cmd_o.srch_init = 1'b1;
            state_d = ST_SRCH_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.mid_step = 1'b1;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.srch_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.srch_issue = 1'b1;
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (sts_i.srch_eq) begin
          cmd_o.srch_match = 1'b1;
          state_d = ST_SRCH_RD;
        end else begin
          state_d = ST_SRCH_SHIFT;
        end
      end
      ST_SRCH_SHIFT: begin
        cmd_o.srch_shift = 1'b1;
        state_d = ST_SRCH_RD;
      end
      ST_DONE: begin
        cmd_o.emit = 1'b1;
        cmd_o.close_text = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/bmss_dp.sv =====
module bmss_dp #(
  parameter int PATTERN_MAX = 64,
  parameter int TEXT_MAX    = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmss_pkg::in_item_t in_i,
  input  bmss_pkg::cmd_t     cmd_i,
  output bmss_pkg::sts_t     sts_o,
  output logic               done_o,
  output bmss_pkg::out_item_t res_o
);
  import bmss_pkg::*;

  localparam int PW = $clog2(PATTERN_MAX + 1);   // holds 0..PATTERN_MAX
  localparam int PI = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int TW = $clog2(TEXT_MAX + 1);
  localparam int TI = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  // signed search position width: covers TEXT_MAX + PATTERN_MAX
  localparam int SW = $clog2(TEXT_MAX + 2 * PATTERN_MAX + 2) + 1;

  // memories
  logic [7:0]    pat_mem [PATTERN_MAX];
  logic [7:0]    txt_mem [TEXT_MAX];
  logic [PW-1:0] bc_mem  [256];   // stored as position+1; 0 means absent
  logic [PW-1:0] gs_mem  [PATTERN_MAX];
  logic [PW-1:0] suf_mem [PATTERN_MAX];

  logic [PW-1:0] plen_q;
  logic [TW-1:0] tlen_q;
  logic          ovf_q;

  // shared index registers
  logic [PW:0]   i_q;     // signed-ish loop index (one extra bit)
  logic [PW:0]   k_q;
  logic [PW:0]   j_q;
  logic [8:0]    bci_q;
  logic signed [SW-1:0] pos_q;

  // registered reads
  logic [7:0]    pa_q, pb_q, tc_q;
  logic [PW-1:0] bc_rd_q, gs_rd_q;
  logic          busy_p_q;

  logic [PW-1:0] m;
  assign m = plen_q;

  // load path
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_byte && in_i.op == OP_PATTERN) begin
      if (cmd_i.new_pattern) pat_mem[0] <= in_i.data_byte;
      else if (plen_q < PW'(PATTERN_MAX)) pat_mem[plen_q[PI-1:0]] <= in_i.data_byte;
    end
    if (cmd_i.ld_byte && in_i.op == OP_TEXT && tlen_q < TW'(TEXT_MAX))
      txt_mem[tlen_q[TI-1:0]] <= in_i.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      tlen_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cmd_i.ld_byte && in_i.op == OP_PATTERN) begin
        if (cmd_i.new_pattern) begin
          plen_q <= PW'(1);
          ovf_q  <= 1'b0;
        end else if (plen_q < PW'(PATTERN_MAX)) begin
          plen_q <= plen_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.ld_byte && in_i.op == OP_TEXT) begin
        if (tlen_q < TW'(TEXT_MAX)) tlen_q <= tlen_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (cmd_i.close_text) tlen_q <= '0;
    end
  end

  // index arithmetic (one extra bit, two's complement)
  logic [PW:0] mm1, mm2, end_k, i_k, jm1;
  assign mm1   = {1'b0, m} - 1'b1;
  assign mm2   = {1'b0, m} - 2'd2;
  assign end_k = mm1 - k_q;
  assign i_k   = i_q - k_q;
  assign jm1   = j_q - 1'b1;

  // suffix comparison: read i-k and end-k
  logic suf_run;
  assign suf_run = !i_q[PW] && (i_q >= k_q);

  // prefix rule: suffix_lengths[i] read registered
  logic [PW-1:0] suf_rd_q;
  logic [PW:0]   ip1;
  assign ip1 = i_q + 1'b1;

  // middle rule index
  logic [PW:0] mid_idx;
  assign mid_idx = mm1 - {1'b0, suf_rd_q};

  // search
  logic signed [SW-1:0] tidx, shift_bc, shift_gs, shift_v;
  logic signed [SW-1:0] mk1;
  assign tidx = pos_q - SW'($signed({1'b0, k_q}));
  assign mk1  = SW'($signed({1'b0, end_k}));
  assign shift_bc = (mk1 > SW'($signed({1'b0, bc_rd_q})) - SW'(1))
                  ? mk1 - (SW'($signed({1'b0, bc_rd_q})) - SW'(1)) : SW'(1);
  assign shift_gs = SW'($signed({1'b0, gs_rd_q}));
  assign shift_v  = (shift_bc > shift_gs) ? shift_bc : shift_gs;

  always_ff @(posedge clk_i) begin
    // bad-character table; pa_q lags i_q by one, so i_q is position+1
    if (cmd_i.bc_clr_step) bc_mem[bci_q[7:0]] <= '0;
    if (cmd_i.bc_fill_step && busy_p_q) bc_mem[pa_q] <= i_q[PW-1:0];
    // pattern read port A: used by fill and suffix compare
    pa_q <= pat_mem[i_k[PI-1:0]];
    pb_q <= pat_mem[end_k[PI-1:0]];
    tc_q <= txt_mem[tidx[TI-1:0]];
    if (cmd_i.suf_init) suf_mem[mm1[PI-1:0]] <= m;
    if (cmd_i.suf_next_i) suf_mem[i_q[PI-1:0]] <= k_q[PW-1:0];
    if (cmd_i.gs_init_step) gs_mem[i_q[PI-1:0]] <= m;
    // gs_rd_q holds entry j-1 here
    if (cmd_i.pref_j_step && busy_p_q && gs_rd_q == m)
      gs_mem[jm1[PI-1:0]] <= mm1[PW-1:0] - i_q[PW-1:0];
    if (cmd_i.mid_step && busy_p_q) gs_mem[mid_idx[PI-1:0]] <= mm1[PW-1:0] - i_q[PW-1:0];
    suf_rd_q <= suf_mem[i_q[PI-1:0]];
    gs_rd_q  <= cmd_i.pref_j_step ? gs_mem[j_q[PI-1:0]] : gs_mem[end_k[PI-1:0]];
    bc_rd_q  <= bc_mem[tc_q];
  end

  // loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; k_q <= '0; j_q <= '0; bci_q <= '0; pos_q <= '0;
      busy_p_q <= 1'b0; done_o <= 1'b0; res_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cmd_i.bc_clr_init) bci_q <= '0;
      if (cmd_i.bc_clr_step) bci_q <= bci_q + 1'b1;
      if (cmd_i.bc_fill_init) begin
        i_q <= '0; k_q <= '0; busy_p_q <= 1'b0;
      end
      if (cmd_i.bc_fill_step) begin
        // pa_q holds pat[i-1] after the registered prefetch
        busy_p_q <= 1'b1;
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.suf_init) begin
        i_q <= mm2; k_q <= '0;
      end
      if (cmd_i.suf_step_k) k_q <= k_q + 1'b1;
      if (cmd_i.suf_next_i) begin
        i_q <= i_q - 1'b1; k_q <= '0;
      end
      if (cmd_i.gs_init) i_q <= '0;
      if (cmd_i.gs_init_step) i_q <= i_q + 1'b1;
      if (cmd_i.pref_init) begin
        i_q <= mm2; busy_p_q <= 1'b0;
      end
      if (cmd_i.pref_j_init) begin
        j_q <= '0; busy_p_q <= 1'b0;
      end
      if (cmd_i.pref_j_step) begin
        busy_p_q <= 1'b1;
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.pref_next_i) begin
        // first pass on an index only waits for the suffix read
        if (busy_p_q) begin
          i_q <= i_q - 1'b1; busy_p_q <= 1'b0;
        end else begin
          busy_p_q <= 1'b1;
        end
      end
      if (cmd_i.mid_init) begin
        i_q <= '0; busy_p_q <= 1'b0;
      end
      if (cmd_i.mid_step) begin
        busy_p_q <= 1'b1;
        if (busy_p_q) begin
          i_q <= i_q + 1'b1; busy_p_q <= 1'b0;
        end
      end
      if (cmd_i.srch_init) begin
        k_q <= '0; pos_q <= SW'($signed({1'b0, mm1}));
      end
      if (cmd_i.srch_match) k_q <= k_q + 1'b1;
      if (cmd_i.srch_shift) begin
        pos_q <= pos_q + shift_v; k_q <= '0;
      end
      if (cmd_i.emit) begin
        done_o <= 1'b1;
        res_o.overflow <= ovf_q;
        if (m == '0) begin
          res_o.found <= 1'b1; res_o.position <= '0;
        end else if (k_q[PW-1:0] == m) begin
          res_o.found <= 1'b1;
          res_o.position <= 10'(pos_q + SW'(1) - SW'($signed({1'b0, m})));
        end else begin
          res_o.found <= 1'b0; res_o.position <= '0;
        end
      end
    end
  end

  // status
  logic fill_wait;
  assign fill_wait = busy_p_q && (i_q == {1'b0, m});
  always_comb begin
    sts_o = '0;
    sts_o.bc_clr_done  = (bci_q == 9'd255);
    sts_o.bc_fill_done = (m == '0) || fill_wait;
    sts_o.pat_empty    = (m == '0);
    sts_o.suf_done     = i_q[PW];
    sts_o.suf_cmp_eq   = suf_run && (pa_q == pb_q);
    sts_o.gs_init_done = (i_q + 1'b1 == {1'b0, m});
    sts_o.pref_done    = i_q[PW];
    sts_o.pref_hit     = busy_p_q && !i_q[PW] && ({1'b0, suf_rd_q} == ip1);
    sts_o.pref_j_done  = busy_p_q && (j_q == mm1 - i_q);
    sts_o.mid_done     = (m == '0) || (i_q[PW] == 1'b0 && i_q > mm2) ||
                         (m == PW'(1));
    sts_o.srch_done    = (k_q[PW-1:0] == m) || (pos_q >= SW'($signed({1'b0, tlen_q})));
    sts_o.srch_eq      = (pb_q == tc_q);
  end

endmodule

// ===== hdl/boyer_moore_substring_search_top.sv =====
// channel | dir | signals                          | transaction
// item    | in  | start, busy, in_item_i           | start && !busy at clk edge
// result  | out | done_o, res_item_o               | done_o high for one cycle
// A pattern or text byte is taken while idle; busy stays low while loading.
// Closing the pattern rebuilds the tables: all 256 bad-character entries are
// cleared, then the fill, suffix, good-suffix and middle-rule loops run.
// Closing the text runs the scan through its read, compare and shift states.
// Reset (rst_ni low) clears lengths, overflow and controller; stores hold junk.
// The result is shown for one cycle; the receiver cannot stall it.
module boyer_moore_substring_search_top #(
  parameter int PATTERN_MAX = 64,
  parameter int TEXT_MAX    = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bmss_pkg::in_item_t  in_item_i,
  output logic                done_o,
  output bmss_pkg::out_item_t res_item_o
);
  import bmss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .in_i   (in_item_i),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  bmss_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_item_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_item_o)
  );

endmodule
